>>> src/pue_pkg.sv
`timescale 1ns / 1ps

package pue_pkg;

    // Port widths fixed by the interface
    localparam int PORT_VERT_BITS  = 8;
    localparam int PORT_SLOT_BITS  = 8;
    localparam int PORT_COUNT_BITS = 9;

    // Widest vertex index any configuration of the block can carry
    localparam int CMD_VERT_BITS = 16;

    // Depth of the queues between front, back and result side
    localparam int QUEUE_DEPTH = 2;

    // One edge to look up, as handed from front to back
    typedef struct packed {
        logic [CMD_VERT_BITS-1:0] from_v;
        logic [CMD_VERT_BITS-1:0] to_v;
        logic                     last;
        logic                     eom;
    } edge_cmd_t;

    // One finished result beat
    typedef struct packed {
        logic [PORT_VERT_BITS-1:0]  from_vertex;
        logic [PORT_VERT_BITS-1:0]  to_vertex;
        logic [PORT_SLOT_BITS-1:0]  line_slot;
        logic                       is_new;
        logic                       table_full;
        logic [PORT_COUNT_BITS-1:0] line_count;
        logic                       last_of_run;
    } result_t;

    // Back end sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_FINISH
    } back_state_t;

endpackage

>>> src/pue_ram.sv
`timescale 1ns / 1ps

module pue_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/pue_fifo.sv
`timescale 1ns / 1ps

module pue_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             push_ok, pop_ok;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign push_ok = push & ~full;
    assign pop_ok  = pop & ~empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push_ok)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        case ({push_ok, pop_ok})
            2'b10:   cnt_next = cnt_reg + CW'(1);
            2'b01:   cnt_next = cnt_reg - CW'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the incoming beat
    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

>>> src/pue_front.sv
`timescale 1ns / 1ps

module pue_front #(
    parameter int VERTEX_BITS = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic [pue_pkg::PORT_VERT_BITS-1:0] vertex,
    input  logic                               end_of_polygon,
    input  logic                               end_of_mesh,
    output logic                               busy,
    output logic                               cmd_push,
    output pue_pkg::edge_cmd_t                 cmd_data,
    input  logic                               cmd_full
);

    localparam int VMAX = pue_pkg::CMD_VERT_BITS;

    logic [VERTEX_BITS-1:0] first_reg, first_next;
    logic [VERTEX_BITS-1:0] prev_reg, prev_next;
    logic                   inside_reg, inside_next;
    logic                   pend0_valid_reg, pend0_valid_next;
    logic                   pend1_valid_reg, pend1_valid_next;
    pue_pkg::edge_cmd_t     pend0_reg, pend0_next;
    pue_pkg::edge_cmd_t     pend1_reg, pend1_next;

    logic [VERTEX_BITS-1:0] vin;
    logic                   eop;
    pue_pkg::edge_cmd_t     step_edge, wrap_edge;

    // Hold at most two pending edges; accept only when none remain
    assign busy     = pend0_valid_reg;
    assign cmd_push = pend0_valid_reg;
    assign cmd_data = pend0_reg;

    assign vin = VERTEX_BITS'(vertex);
    assign eop = end_of_polygon | end_of_mesh;

    // Form the edge to the previous corner and the wrap edge to the first
    always_comb
    begin
        step_edge.from_v = VMAX'(prev_reg);
        step_edge.to_v   = VMAX'(vin);
        step_edge.last   = ~eop;
        step_edge.eom    = 1'b0;

        wrap_edge.from_v = VMAX'(vin);
        wrap_edge.to_v   = inside_reg ? VMAX'(first_reg) : VMAX'(vin);
        wrap_edge.last   = 1'b1;
        wrap_edge.eom    = end_of_mesh;
    end

    always_comb
    begin
        first_next       = first_reg;
        prev_next        = prev_reg;
        inside_next      = inside_reg;
        pend0_next       = pend0_reg;
        pend1_next       = pend1_reg;
        pend0_valid_next = pend0_valid_reg;
        pend1_valid_next = pend1_valid_reg;

        // Drain: shift the second pending edge forward
        if (pend0_valid_reg && !cmd_full)
        begin
            pend0_next       = pend1_reg;
            pend0_valid_next = pend1_valid_reg;
            pend1_valid_next = 1'b0;
        end

        // Accept a corner and queue its edges
        if (in_valid)
        begin
            if (inside_reg)
            begin
                pend0_next       = step_edge;
                pend0_valid_next = 1'b1;
                pend1_next       = wrap_edge;
                pend1_valid_next = eop;
            end
            else
            begin
                pend0_next       = wrap_edge;
                pend0_valid_next = eop;
                pend1_valid_next = 1'b0;
                first_next       = vin;
            end
            prev_next   = vin;
            inside_next = ~eop;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg       <= '0;
            prev_reg        <= '0;
            inside_reg      <= 1'b0;
            pend0_valid_reg <= 1'b0;
            pend1_valid_reg <= 1'b0;
        end
        else
        begin
            first_reg       <= first_next;
            prev_reg        <= prev_next;
            inside_reg      <= inside_next;
            pend0_valid_reg <= pend0_valid_next;
            pend1_valid_reg <= pend1_valid_next;
        end
    end

    // Edge payload
    always_ff @(posedge clk)
    begin
        pend0_reg <= pend0_next;
        pend1_reg <= pend1_next;
    end

endmodule

>>> src/pue_back.sv
`timescale 1ns / 1ps

module pue_back #(
    parameter int MAX_EDGES   = 256,
    parameter int VERTEX_BITS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  pue_pkg::edge_cmd_t cmd_data,
    input  logic               cmd_empty,
    output logic               cmd_pop,
    output logic               res_push,
    output pue_pkg::result_t   res_data,
    input  logic               res_full
);

    localparam int AW = $clog2(MAX_EDGES);
    localparam int CW = $clog2(MAX_EDGES + 1);
    localparam int VB = VERTEX_BITS;
    localparam int OV = pue_pkg::PORT_VERT_BITS;
    localparam int OS = pue_pkg::PORT_SLOT_BITS;
    localparam int OC = pue_pkg::PORT_COUNT_BITS;

    pue_pkg::back_state_t state_reg, state_next;
    pue_pkg::edge_cmd_t   cmd_reg, cmd_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        scan_idx_reg, scan_idx_next;
    logic                 chk_valid_reg, chk_valid_next;
    logic [CW-1:0]        chk_idx_reg, chk_idx_next;
    logic                 found_reg, found_next;
    logic [AW-1:0]        slot_reg, slot_next;

    logic                 ram_we, ram_re;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [2*VB-1:0]      ram_wdata, ram_rdata;

    logic [VB-1:0]        a_v, b_v, x_v, y_v;
    logic                 match, room, issue;
    logic [CW-1:0]        slot_out, count_out;
    logic [31:0]          slot_wide, count_wide;

    pue_ram #(
        .WIDTH (2 * VB),
        .DEPTH (MAX_EDGES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Compare the returned entry against the edge in either direction
    assign a_v   = cmd_reg.from_v[VB-1:0];
    assign b_v   = cmd_reg.to_v[VB-1:0];
    assign x_v   = ram_rdata[2*VB-1:VB];
    assign y_v   = ram_rdata[VB-1:0];
    assign match = ((x_v == a_v) && (y_v == b_v)) || ((x_v == b_v) && (y_v == a_v));
    assign room  = (count_reg < CW'(MAX_EDGES));
    assign issue = (state_reg == pue_pkg::BK_SCAN) && (scan_idx_reg < count_reg);

    assign ram_re    = issue;
    assign ram_raddr = scan_idx_reg[AW-1:0];
    assign ram_waddr = count_reg[AW-1:0];
    assign ram_wdata = {a_v, b_v};

    // Build the result beat
    always_comb
    begin
        if (found_reg)
        begin
            slot_out  = CW'(slot_reg);
            count_out = count_reg;
        end
        else if (room)
        begin
            slot_out  = count_reg;
            count_out = count_reg + CW'(1);
        end
        else
        begin
            slot_out  = '0;
            count_out = count_reg;
        end
        slot_wide  = 32'(slot_out);
        count_wide = 32'(count_out);

        res_data.from_vertex = cmd_reg.from_v[OV-1:0];
        res_data.to_vertex   = cmd_reg.to_v[OV-1:0];
        res_data.line_slot   = slot_wide[OS-1:0];
        res_data.is_new      = ~found_reg & room;
        res_data.table_full  = ~found_reg & ~room;
        res_data.line_count  = count_wide[OC-1:0];
        res_data.last_of_run = cmd_reg.last;
    end

    // Sequencer: take an edge, scan the table one entry a cycle, finish
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        count_next     = count_reg;
        scan_idx_next  = scan_idx_reg;
        chk_valid_next = 1'b0;
        chk_idx_next   = chk_idx_reg;
        found_next     = found_reg;
        slot_next      = slot_reg;
        cmd_pop        = 1'b0;
        res_push       = 1'b0;
        ram_we         = 1'b0;

        case (state_reg)
            pue_pkg::BK_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop       = 1'b1;
                    cmd_next      = cmd_data;
                    found_next    = 1'b0;
                    scan_idx_next = '0;
                    state_next    = (count_reg == '0) ? pue_pkg::BK_FINISH : pue_pkg::BK_SCAN;
                end
            end

            pue_pkg::BK_SCAN:
            begin
                if (issue)
                begin
                    scan_idx_next  = scan_idx_reg + CW'(1);
                    chk_valid_next = 1'b1;
                    chk_idx_next   = scan_idx_reg;
                end
                if (chk_valid_reg)
                begin
                    if (match)
                    begin
                        found_next     = 1'b1;
                        slot_next      = chk_idx_reg[AW-1:0];
                        chk_valid_next = 1'b0;
                        state_next     = pue_pkg::BK_FINISH;
                    end
                    else if (chk_idx_reg == count_reg - CW'(1))
                    begin
                        chk_valid_next = 1'b0;
                        state_next     = pue_pkg::BK_FINISH;
                    end
                end
            end

            pue_pkg::BK_FINISH:
            begin
                if (!res_full)
                begin
                    res_push = 1'b1;
                    if (!found_reg && room)
                    begin
                        ram_we     = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                    if (cmd_reg.eom)
                    begin
                        count_next = '0;
                    end
                    state_next = pue_pkg::BK_IDLE;
                end
            end

            default:
            begin
                state_next = pue_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pue_pkg::BK_IDLE;
            count_reg     <= '0;
            scan_idx_reg  <= '0;
            chk_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_idx_reg  <= scan_idx_next;
            chk_valid_reg <= chk_valid_next;
        end
    end

    // Edge payload and scan bookkeeping
    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        chk_idx_reg <= chk_idx_next;
        found_reg   <= found_next;
        slot_reg    <= slot_next;
    end

endmodule

>>> src/polygon_unique_edge_extractor.sv
`timescale 1ns / 1ps

// Unique edge extractor. Push one polygon corner per beat; each corner after
// the first yields the edge from the previous corner, and the closing corner
// also yields the wrap edge back to the first corner, so a beat gives zero,
// one or two result beats. Each edge is looked up in the edge table by a
// linear scan that reads one stored entry per cycle from a table memory
// with separate write and read ports, so a lookup grows longer with the
// number of edges stored so far. The table needs no clearing pass: end of
// mesh simply rewinds the fill count, and only slots below it are ever
// read. A small queue between the corner front end and the lookup engine,
// and another on the result side, let either side stall on its own.
module polygon_unique_edge_extractor #(
    parameter int MAX_EDGES   = 256,
    parameter int VERTEX_BITS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [pue_pkg::PORT_VERT_BITS-1:0]  vertex,
    input  logic                                end_of_polygon,
    input  logic                                end_of_mesh,
    output logic                                empty,
    input  logic                                pop,
    output logic [pue_pkg::PORT_VERT_BITS-1:0]  from_vertex,
    output logic [pue_pkg::PORT_VERT_BITS-1:0]  to_vertex,
    output logic [pue_pkg::PORT_SLOT_BITS-1:0]  line_slot,
    output logic                                is_new,
    output logic                                table_full,
    output logic [pue_pkg::PORT_COUNT_BITS-1:0] line_count,
    output logic                                last_of_run
);

    localparam int CMD_W = $bits(pue_pkg::edge_cmd_t);
    localparam int RES_W = $bits(pue_pkg::result_t);

    logic               front_busy, in_valid;
    logic               cmd_push, cmd_full, cmd_empty, cmd_pop;
    pue_pkg::edge_cmd_t cmd_wdata, cmd_rdata;
    logic               res_push, res_full;
    pue_pkg::result_t   res_wdata, res_rdata;

    // Accept a corner beat when the front end holds no pending edges
    assign full     = front_busy;
    assign in_valid = push & ~front_busy;

    pue_front #(
        .VERTEX_BITS (VERTEX_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .vertex         (vertex),
        .end_of_polygon (end_of_polygon),
        .end_of_mesh    (end_of_mesh),
        .busy           (front_busy),
        .cmd_push       (cmd_push),
        .cmd_data       (cmd_wdata),
        .cmd_full       (cmd_full)
    );

    pue_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (pue_pkg::QUEUE_DEPTH)
    ) u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (cmd_wdata),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .rdata (cmd_rdata),
        .empty (cmd_empty)
    );

    pue_back #(
        .MAX_EDGES   (MAX_EDGES),
        .VERTEX_BITS (VERTEX_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_data  (cmd_rdata),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res_push  (res_push),
        .res_data  (res_wdata),
        .res_full  (res_full)
    );

    pue_fifo #(
        .WIDTH (RES_W),
        .DEPTH (pue_pkg::QUEUE_DEPTH)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_wdata),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty)
    );

    // Present the oldest result beat
    assign from_vertex = res_rdata.from_vertex;
    assign to_vertex   = res_rdata.to_vertex;
    assign line_slot   = res_rdata.line_slot;
    assign is_new      = res_rdata.is_new;
    assign table_full  = res_rdata.table_full;
    assign line_count  = res_rdata.line_count;
    assign last_of_run = res_rdata.last_of_run;

endmodule
